// ===== rtl/dual_sensor_oversample_scaler_unit_macros.svh =====
// assertion macros for the oversample scaler
`ifndef DUAL_SENSOR_OVERSAMPLE_SCALER_UNIT_MACROS_SVH
`define DUAL_SENSOR_OVERSAMPLE_SCALER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define DSOS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dsos assertion failed");

`define DSOS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dsos assertion failed");

`else

`define DSOS_ASSERT_NOW(label, clk, rst_n, ante, cons)

`define DSOS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/dsos_pkg.sv =====
`default_nettype none

package dsos_pkg;

    localparam int OVERSAMPLE_LOG2 = 3;
    localparam int OVERSAMPLE      = 1 << OVERSAMPLE_LOG2;

    localparam int DATA_W   = 10;
    localparam int LEVEL_W  = 8;
    localparam int SUM_W    = 16;
    localparam int PAIR_W   = 7;
    localparam int AVG_W    = SUM_W - OVERSAMPLE_LOG2;
    localparam int CNT_W    = $clog2(DATA_W);
    localparam int ADDR_W   = 5;
    localparam int PDATA_W  = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_MIN_A    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAX_A    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DIV_A    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MIN_B    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MAX_B    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DIV_B    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_INVERT_A = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_INVERT_B = 3'd7;

    typedef struct packed {
        logic [DATA_W-1:0] min_a;
        logic [DATA_W-1:0] max_a;
        logic [DATA_W-1:0] div_a;
        logic [DATA_W-1:0] min_b;
        logic [DATA_W-1:0] max_b;
        logic [DATA_W-1:0] div_b;
        logic              invert_a;
        logic              invert_b;
    } dsos_cfg_t;

    typedef struct packed {
        logic             go;
        logic             chan;
        logic [SUM_W-1:0] sum;
    } dsos_job_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic               chan;
        logic [LEVEL_W-1:0] level;
    } dsos_res_t;

endpackage

`default_nettype wire

// ===== rtl/dual_sensor_oversample_scaler_unit.sv =====
// Averages conversion results that alternate between sensor A and sensor B (A first) over
// eight samples per sensor, clamps each average to the sensor's min and max, subtracts the
// min, optionally mirrors it against the span, and divides by the sensor's divisor into a
// level saturated at 255 (a zero divisor gives 255). A request that does not finish a group
// is accepted while the scaler is idle. A request that finishes a group holds the input
// off while the sum is latched, clamped and mirrored, divided by the bit-serial restoring
// divider (one quotient bit per cycle) and handed to the output register. While that
// register still holds an earlier result that has not been taken, the divider keeps its
// result and the input stays held off until the output register drains.
`default_nettype none

`include "dual_sensor_oversample_scaler_unit_macros.svh"

module dual_sensor_oversample_scaler_unit
    import dsos_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [DATA_W-1:0]  sample,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    channel,
    output logic [LEVEL_W-1:0]      level
);

    dsos_cfg_t          cfg_reg;
    dsos_job_t          job;
    dsos_res_t          res;
    logic               take;
    logic               out_valid_reg, out_valid_next;
    logic               channel_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic               wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_a    <= '0;
            cfg_reg.max_a    <= '1;
            cfg_reg.div_a    <= DATA_W'(4);
            cfg_reg.min_b    <= '0;
            cfg_reg.max_b    <= '1;
            cfg_reg.div_b    <= DATA_W'(4);
            cfg_reg.invert_a <= 1'b0;
            cfg_reg.invert_b <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_MIN_A:    cfg_reg.min_a    <= pwdata[DATA_W-1:0];
                REG_MAX_A:    cfg_reg.max_a    <= pwdata[DATA_W-1:0];
                REG_DIV_A:    cfg_reg.div_a    <= pwdata[DATA_W-1:0];
                REG_MIN_B:    cfg_reg.min_b    <= pwdata[DATA_W-1:0];
                REG_MAX_B:    cfg_reg.max_b    <= pwdata[DATA_W-1:0];
                REG_DIV_B:    cfg_reg.div_b    <= pwdata[DATA_W-1:0];
                REG_INVERT_A: cfg_reg.invert_a <= pwdata[0];
                REG_INVERT_B: cfg_reg.invert_b <= pwdata[0];
                default:      cfg_reg.min_a    <= cfg_reg.min_a;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MIN_A:    prdata = PDATA_W'(cfg_reg.min_a);
            REG_MAX_A:    prdata = PDATA_W'(cfg_reg.max_a);
            REG_DIV_A:    prdata = PDATA_W'(cfg_reg.div_a);
            REG_MIN_B:    prdata = PDATA_W'(cfg_reg.min_b);
            REG_MAX_B:    prdata = PDATA_W'(cfg_reg.max_b);
            REG_DIV_B:    prdata = PDATA_W'(cfg_reg.div_b);
            REG_INVERT_A: prdata = PDATA_W'(cfg_reg.invert_a);
            REG_INVERT_B: prdata = PDATA_W'(cfg_reg.invert_b);
            default:      prdata = '0;
        endcase
    end

    assign in_ready = !job.go && !res.busy;

    dsos_accum u_accum
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (in_valid && in_ready),
        .sample (sample),
        .job    (job)
    );

    dsos_scaler u_scaler
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .job   (job),
        .take  (take),
        .res   (res)
    );

    // output register, loads when empty or being drained
    assign take = res.done && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            channel_reg <= res.chan;
            level_reg   <= res.level;
        end
    end

    assign out_valid = out_valid_reg;
    assign channel   = channel_reg;
    assign level     = level_reg;

    `DSOS_ASSERT_NEXT(a_go_starts_scaler, clk, rst_n, job.go, res.busy)
    `DSOS_ASSERT_NEXT(a_go_single_pulse, clk, rst_n, job.go, !job.go)
    `DSOS_ASSERT_NOW(a_out_from_scaler, clk, rst_n, $rose(out_valid_reg), $past(res.done))

endmodule

`default_nettype wire

// ===== rtl/dsos_accum.sv =====
`default_nettype none

module dsos_accum
    import dsos_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [DATA_W-1:0] sample,
    output dsos_job_t              job
);

    logic              next_is_b_reg, next_is_b_next;
    logic [PAIR_W-1:0] pair_count_reg, pair_count_next;
    logic [SUM_W-1:0]  sum_a_reg, sum_a_next;
    logic [SUM_W-1:0]  sum_b_reg, sum_b_next;
    dsos_job_t         job_reg, job_next;
    logic [SUM_W-1:0]  sum_add;
    logic [PAIR_W-1:0] pair_inc;

    assign sum_add  = (next_is_b_reg ? sum_b_reg : sum_a_reg) + SUM_W'(sample);
    assign pair_inc = pair_count_reg + PAIR_W'(1);

    always_comb
    begin
        next_is_b_next  = next_is_b_reg;
        pair_count_next = pair_count_reg;
        sum_a_next      = sum_a_reg;
        sum_b_next      = sum_b_reg;
        job_next        = '{go: 1'b0, chan: next_is_b_reg, sum: sum_add};
        if (accept)
        begin
            next_is_b_next = !next_is_b_reg;
            if (!next_is_b_reg)
            begin
                sum_a_next = sum_add;
                if (pair_count_reg == PAIR_W'(OVERSAMPLE - 1))
                begin
                    job_next.go = 1'b1;
                    sum_a_next  = '0;
                end
            end
            else
            begin
                sum_b_next      = sum_add;
                pair_count_next = pair_inc;
                if (pair_inc == PAIR_W'(OVERSAMPLE))
                begin
                    job_next.go     = 1'b1;
                    sum_b_next      = '0;
                    pair_count_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_is_b_reg  <= 1'b0;
            pair_count_reg <= '0;
            sum_a_reg      <= '0;
            sum_b_reg      <= '0;
            job_reg        <= '0;
        end
        else
        begin
            next_is_b_reg  <= next_is_b_next;
            pair_count_reg <= pair_count_next;
            sum_a_reg      <= sum_a_next;
            sum_b_reg      <= sum_b_next;
            job_reg        <= job_next;
        end
    end

    assign job = job_reg;

endmodule

`default_nettype wire

// ===== rtl/dsos_scaler.sv =====
`default_nettype none

module dsos_scaler
    import dsos_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire dsos_cfg_t cfg,
    input  wire dsos_job_t job,
    input  wire logic      take,
    output dsos_res_t      res
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CLAMP  = 3'd1;
    localparam logic [2:0] S_MIRROR = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic              chan_reg, chan_next;
    logic [AVG_W-1:0]  avg_reg, avg_next;
    logic [DATA_W-1:0] off_reg, off_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic [DATA_W-1:0] lo, hi, dv;
    logic              inv;
    logic [DATA_W-1:0] clamped, off_c, span, mir;
    logic [DATA_W+1:0] trial;
    logic              fits;

    assign lo  = chan_reg ? cfg.min_b : cfg.min_a;
    assign hi  = chan_reg ? cfg.max_b : cfg.max_a;
    assign dv  = chan_reg ? cfg.div_b : cfg.div_a;
    assign inv = chan_reg ? cfg.invert_b : cfg.invert_a;

    always_comb
    begin
        priority if (avg_reg > AVG_W'(hi))
            clamped = hi;
        else if (avg_reg < AVG_W'(lo))
            clamped = lo;
        else
            clamped = avg_reg[DATA_W-1:0];
    end

    assign off_c = (clamped >= lo) ? clamped - lo : '0;
    assign span  = (hi >= lo) ? hi - lo : '0;
    assign mir   = (span >= off_reg) ? span - off_reg : '0;

    // one restoring step per cycle, quotient bits shift in from the right
    assign trial = {1'b0, rem_reg, quo_reg[DATA_W-1]} - {2'b00, dv};
    assign fits  = !trial[DATA_W+1];

    always_comb
    begin
        state_next = state_reg;
        chan_next  = chan_reg;
        avg_next   = avg_reg;
        off_next   = off_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (job.go)
                begin
                    chan_next  = job.chan;
                    avg_next   = job.sum[SUM_W-1:OVERSAMPLE_LOG2];
                    state_next = S_CLAMP;
                end
            end
            S_CLAMP:
            begin
                off_next   = off_c;
                state_next = S_MIRROR;
            end
            S_MIRROR:
            begin
                quo_next   = inv ? mir : off_reg;
                rem_next   = '0;
                cnt_next   = CNT_W'(DATA_W - 1);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                quo_next = {quo_reg[DATA_W-2:0], fits};
                rem_next = fits ? trial[DATA_W-1:0] : {rem_reg[DATA_W-2:0], quo_reg[DATA_W-1]};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chan_reg <= chan_next;
        avg_reg  <= avg_next;
        off_reg  <= off_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
    end

    assign res.busy  = (state_reg != S_IDLE);
    assign res.done  = (state_reg == S_DONE);
    assign res.chan  = chan_reg;
    assign res.level = (|quo_reg[DATA_W-1:LEVEL_W]) ? '1 : quo_reg[LEVEL_W-1:0];

endmodule

`default_nettype wire
